// ----- design/usf_pkg.sv -----
package usf_pkg;

    // fixed field widths
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned IN_ADDR_W  = 12;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 13;
    localparam int unsigned MAGIC_W    = 32;
    localparam int unsigned SHIFT_W    = 4;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned HDR_W      = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 16;
    // record positions: length plus one full sector still fits
    localparam int unsigned FADDR_W    = 17;
    localparam int unsigned HCNT_W     = 4;

    localparam logic [HCNT_W-1:0]  HDR_READS    = 4'd8;
    localparam logic [LEN_W-1:0]   LEN_RST      = 13'd1024;
    localparam logic [MAGIC_W-1:0] MAGIC_RST    = 32'h454C_4946;
    localparam logic [SHIFT_W-1:0] SHIFT_RST    = 4'd9;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FIXUP = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_MAGIC   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH = 2'd0,
        CFG_MAGIC  = 2'd1,
        CFG_SHIFT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ASEL_IN,
        ASEL_HDR,
        ASEL_USN0,
        ASEL_USN1,
        ASEL_POS0,
        ASEL_POS1,
        ASEL_ENT0,
        ASEL_ENT1
    } addr_sel_t;

    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_ENT_LO,
        WSEL_ENT_HI
    } wdata_sel_t;

    typedef struct packed {
        logic       mem_re;
        logic       mem_we;
        addr_sel_t  asel;
        wdata_sel_t wsel;
        logic [2:0] hdr_idx;
        logic       hdr_cap;
        logic       usn_lo_cap;
        logic       usn_hi_cap;
        logic       word_lo_cap;
        logic       word_hi_cap;
        logic       ent_lo_cap;
        logic       walk_init;
        logic       entry_step;
        logic       pos_step;
    } cmd_t;

    typedef struct packed {
        logic              len_bad;
        logic              magic_bad;
        logic              off_bad;
        logic              count_bad;
        logic              sector_bad;
        logic              walk_done;
        logic              entry_bad;
        logic              word_bad;
        logic [BYTE_W-1:0] rd_byte;
    } sts_t;

    typedef struct packed {
        status_t           fix_status;
        logic [BYTE_W-1:0] read_byte;
    } res_t;

endpackage

// ----- design/update_sequence_fixup.sv -----
// update-sequence fixup engine over a byte record store
//
// input channel (s_*): one transfer per item; s_tuser carries the kind
// (load byte, run fixup, read byte), s_tdata the byte address and value.
// result channel (m_*): exactly one transfer per accepted item, carrying the
// read byte (zero unless a read) and the fixup status (zero unless a fixup).
// cfg_*: plain register writes (record length, magic word, sector shift);
// the user must make them only while the block is idle; the block does not enforce it.
//
// timing: a load is written and its result queued in the cycle it is taken;
// a read is answered from the registered store read. a fixup runs on the
// controller/datapath pair, at most one store access per cycle: header work,
// then per sector visited a test, two sector-end reads, two entry reads, two writes;
// early rejects end at the length or header checks. a fixup holds intake.
//
// results go through a two-entry queue, so new items keep being taken while
// a finished result waits; when the receiver stalls and the queue fills,
// s_tready drops until a result transfer frees a slot.
// reset clears the controller, the queue and the config registers to their defaults;
// store contents are undefined until written.
module update_sequence_fixup #(
    parameter int unsigned RECORD_BYTES = 4096,
    parameter int unsigned HEADER_BYTES = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [usf_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] byte_address, [19:12] byte_value
    input  logic [usf_pkg::KIND_W-1:0]        s_tuser,   // [1:0] kind
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [usf_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] read_byte, [9:8] fix_status
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [usf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [usf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    usf_pkg::cmd_t cmd;
    usf_pkg::sts_t sts;
    usf_pkg::res_t push_res;
    logic          push;
    logic          q_full;

    // sequencer: item intake, header checks and the sector walk
    usf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .q_full   (q_full),
        .sts      (sts),
        .cmd      (cmd),
        .push     (push),
        .push_res (push_res)
    );

    // record store, config registers and walk pointers
    usf_dpath #(
        .RECORD_BYTES (RECORD_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_addr   (s_tdata[11:0]),
        .in_byte   (s_tdata[19:12]),
        .cmd       (cmd),
        .sts       (sts)
    );

    // result queue decouples the receiver from the sequencer
    usf_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .full     (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- design/usf_dpath.sv -----
module usf_dpath #(
    parameter int unsigned RECORD_BYTES = 4096,
    parameter int unsigned HEADER_BYTES = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [usf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [usf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [usf_pkg::IN_ADDR_W-1:0]      in_addr,
    input  logic [usf_pkg::BYTE_W-1:0]         in_byte,
    input  usf_pkg::cmd_t                      cmd,
    output usf_pkg::sts_t                      sts
);

    localparam int unsigned AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam logic [usf_pkg::FADDR_W-1:0] REC_LIMIT = usf_pkg::FADDR_W'(RECORD_BYTES);
    localparam logic [usf_pkg::FADDR_W-1:0] HDR_LIMIT = usf_pkg::FADDR_W'(HEADER_BYTES);

    logic [usf_pkg::LEN_W-1:0]   len_reg;
    logic [usf_pkg::MAGIC_W-1:0] magic_reg;
    logic [usf_pkg::SHIFT_W-1:0] shift_reg;

    logic [usf_pkg::HDR_W-1:0]   hdr_reg;
    logic [usf_pkg::WORD_W-1:0]  usn_reg;
    logic [usf_pkg::WORD_W-1:0]  word_reg;
    logic [usf_pkg::BYTE_W-1:0]  ent_lo_reg;
    logic [usf_pkg::FADDR_W-1:0] pos_reg;
    logic [usf_pkg::FADDR_W-1:0] entry_reg;
    logic [usf_pkg::BYTE_W-1:0]  rd_data_reg;
    logic                        oob_reg;

    logic [usf_pkg::BYTE_W-1:0]  store_mem [RECORD_BYTES];

    logic [usf_pkg::FADDR_W-1:0] len_ext;
    logic [usf_pkg::FADDR_W-1:0] usa_ext;
    logic [usf_pkg::FADDR_W-1:0] sector;
    logic [usf_pkg::WORD_W-1:0]  count;
    logic [usf_pkg::FADDR_W-1:0] full_addr;
    logic                        in_range;
    logic [AW-1:0]               mem_idx;
    logic [usf_pkg::BYTE_W-1:0]  wdata;
    logic                        alias_hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= usf_pkg::LEN_RST;
            magic_reg <= usf_pkg::MAGIC_RST;
            shift_reg <= usf_pkg::SHIFT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                usf_pkg::CFG_LENGTH: len_reg   <= cfg_wdata[usf_pkg::LEN_W-1:0];
                usf_pkg::CFG_MAGIC:  magic_reg <= cfg_wdata[usf_pkg::MAGIC_W-1:0];
                usf_pkg::CFG_SHIFT:  shift_reg <= cfg_wdata[usf_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_ext = usf_pkg::FADDR_W'(len_reg);
    assign usa_ext = usf_pkg::FADDR_W'(hdr_reg[47:32]);
    assign count   = hdr_reg[63:48];
    assign sector  = {{(usf_pkg::FADDR_W-1){1'b0}}, 1'b1} << shift_reg;

    // address select
    always_comb begin
        case (cmd.asel)
            usf_pkg::ASEL_IN:   full_addr = usf_pkg::FADDR_W'(in_addr);
            usf_pkg::ASEL_HDR:  full_addr = usf_pkg::FADDR_W'(cmd.hdr_idx);
            usf_pkg::ASEL_USN0: full_addr = usa_ext;
            usf_pkg::ASEL_USN1: full_addr = usa_ext + usf_pkg::FADDR_W'(1);
            usf_pkg::ASEL_POS0: full_addr = pos_reg;
            usf_pkg::ASEL_POS1: full_addr = pos_reg + usf_pkg::FADDR_W'(1);
            usf_pkg::ASEL_ENT0: full_addr = entry_reg;
            usf_pkg::ASEL_ENT1: full_addr = entry_reg + usf_pkg::FADDR_W'(1);
            default:            full_addr = '0;
        endcase
    end

    assign in_range = full_addr < REC_LIMIT;
    assign mem_idx  = full_addr[AW-1:0];

    // second entry byte sits where the first one was just written
    assign alias_hit = (entry_reg + usf_pkg::FADDR_W'(1)) == pos_reg;

    always_comb begin
        case (cmd.wsel)
            usf_pkg::WSEL_IN:     wdata = in_byte;
            usf_pkg::WSEL_ENT_LO: wdata = ent_lo_reg;
            usf_pkg::WSEL_ENT_HI: wdata = alias_hit ? ent_lo_reg : rd_data_reg;
            default:              wdata = in_byte;
        endcase
    end

    // record store, one access per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_we && in_range) begin
            store_mem[mem_idx] <= wdata;
        end
        if (cmd.mem_re) begin
            rd_data_reg <= store_mem[mem_idx];
            oob_reg     <= !in_range;
        end
    end

    // walk registers
    always_ff @(posedge aclk) begin
        if (cmd.hdr_cap) begin
            hdr_reg <= {rd_data_reg, hdr_reg[usf_pkg::HDR_W-1:usf_pkg::BYTE_W]};
        end
        if (cmd.usn_lo_cap) begin
            usn_reg[7:0] <= rd_data_reg;
        end
        if (cmd.usn_hi_cap) begin
            usn_reg[15:8] <= rd_data_reg;
        end
        if (cmd.word_lo_cap) begin
            word_reg[7:0] <= rd_data_reg;
        end
        if (cmd.word_hi_cap) begin
            word_reg[15:8] <= rd_data_reg;
        end
        if (cmd.ent_lo_cap) begin
            ent_lo_reg <= rd_data_reg;
        end
        if (cmd.walk_init) begin
            pos_reg   <= sector - usf_pkg::FADDR_W'(2);
            entry_reg <= usa_ext;
        end else begin
            if (cmd.entry_step) begin
                entry_reg <= entry_reg + usf_pkg::FADDR_W'(2);
            end
            if (cmd.pos_step) begin
                pos_reg <= pos_reg + sector;
            end
        end
    end

    // checks; a sector size of one wraps and always fails
    assign sts.len_bad    = (len_ext > REC_LIMIT) || (len_ext < HDR_LIMIT);
    assign sts.magic_bad  = hdr_reg[31:0] != magic_reg;
    assign sts.off_bad    = (usa_ext + usf_pkg::FADDR_W'(2)) > len_ext;
    assign sts.count_bad  = (count == '0) ||
                            ((count - usf_pkg::WORD_W'(1)) !=
                             usf_pkg::WORD_W'(len_reg >> shift_reg));
    assign sts.sector_bad = len_ext < (sector - usf_pkg::FADDR_W'(2));
    assign sts.walk_done  = (pos_reg + usf_pkg::FADDR_W'(2)) > len_ext;
    assign sts.entry_bad  = (entry_reg + usf_pkg::FADDR_W'(4)) > len_ext;
    assign sts.word_bad   = word_reg != usn_reg;
    assign sts.rd_byte    = oob_reg ? '0 : rd_data_reg;

    a_single_port : assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_we && cmd.mem_re))
        else $error("store read and written in one cycle");

endmodule

// ----- design/usf_ctrl.sv -----
module usf_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [usf_pkg::KIND_W-1:0]    s_kind,
    input  logic                          q_full,
    input  usf_pkg::sts_t                 sts,
    output usf_pkg::cmd_t                 cmd,
    output logic                          push,
    output usf_pkg::res_t                 push_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LEN,
        S_HDR,
        S_HDR_CHK,
        S_USN0,
        S_USN1,
        S_USN2,
        S_W_TEST,
        S_RD_P0,
        S_RD_P1,
        S_RD_E0,
        S_RD_E1,
        S_WR0,
        S_WR1,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [usf_pkg::HCNT_W-1:0]   cnt_reg, cnt_next;
    usf_pkg::status_t             status_reg, status_next;
    logic                         accept;

    assign s_tready = (state_reg == S_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        cmd         = '0;
        push        = 1'b0;
        push_res.read_byte  = '0;
        push_res.fix_status = usf_pkg::ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        usf_pkg::KIND_LOAD: begin
                            cmd.mem_we = 1'b1;
                            cmd.asel   = usf_pkg::ASEL_IN;
                            cmd.wsel   = usf_pkg::WSEL_IN;
                            push       = 1'b1;
                        end
                        usf_pkg::KIND_READ: begin
                            cmd.mem_re = 1'b1;
                            cmd.asel   = usf_pkg::ASEL_IN;
                            state_next = S_READ;
                        end
                        usf_pkg::KIND_FIXUP: begin
                            state_next = S_LEN;
                        end
                        default: begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                push               = 1'b1;
                push_res.read_byte = sts.rd_byte;
                state_next         = S_IDLE;
            end
            S_LEN: begin
                cnt_next = '0;
                if (sts.len_bad) begin
                    status_next = usf_pkg::ST_CORRUPT;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_HDR;
                end
            end
            S_HDR: begin
                cmd.mem_re  = (cnt_reg != usf_pkg::HDR_READS);
                cmd.asel    = usf_pkg::ASEL_HDR;
                cmd.hdr_idx = cnt_reg[2:0];
                cmd.hdr_cap = (cnt_reg != '0);
                cnt_next    = cnt_reg + usf_pkg::HCNT_W'(1);
                if (cnt_reg == usf_pkg::HDR_READS) begin
                    state_next = S_HDR_CHK;
                end
            end
            S_HDR_CHK: begin
                if (sts.magic_bad) begin
                    status_next = usf_pkg::ST_MAGIC;
                    state_next  = S_DONE;
                end else if (sts.off_bad || sts.count_bad || sts.sector_bad) begin
                    status_next = usf_pkg::ST_CORRUPT;
                    state_next  = S_DONE;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_USN0;
                end
            end
            S_USN0: begin
                cmd.mem_re = 1'b1;
                cmd.asel   = usf_pkg::ASEL_USN0;
                state_next = S_USN1;
            end
            S_USN1: begin
                cmd.mem_re     = 1'b1;
                cmd.asel       = usf_pkg::ASEL_USN1;
                cmd.usn_lo_cap = 1'b1;
                state_next     = S_USN2;
            end
            S_USN2: begin
                cmd.usn_hi_cap = 1'b1;
                state_next     = S_W_TEST;
            end
            S_W_TEST: begin
                if (sts.walk_done) begin
                    status_next = usf_pkg::ST_OK;
                    state_next  = S_DONE;
                end else if (sts.entry_bad) begin
                    status_next = usf_pkg::ST_CORRUPT;
                    state_next  = S_DONE;
                end else begin
                    cmd.entry_step = 1'b1;
                    state_next     = S_RD_P0;
                end
            end
            S_RD_P0: begin
                cmd.mem_re = 1'b1;
                cmd.asel   = usf_pkg::ASEL_POS0;
                state_next = S_RD_P1;
            end
            S_RD_P1: begin
                cmd.mem_re      = 1'b1;
                cmd.asel        = usf_pkg::ASEL_POS1;
                cmd.word_lo_cap = 1'b1;
                state_next      = S_RD_E0;
            end
            S_RD_E0: begin
                cmd.mem_re      = 1'b1;
                cmd.asel        = usf_pkg::ASEL_ENT0;
                cmd.word_hi_cap = 1'b1;
                state_next      = S_RD_E1;
            end
            S_RD_E1: begin
                cmd.mem_re     = 1'b1;
                cmd.asel       = usf_pkg::ASEL_ENT1;
                cmd.ent_lo_cap = 1'b1;
                if (sts.word_bad) begin
                    status_next = usf_pkg::ST_CORRUPT;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_WR0;
                end
            end
            S_WR0: begin
                cmd.mem_we = 1'b1;
                cmd.asel   = usf_pkg::ASEL_POS0;
                cmd.wsel   = usf_pkg::WSEL_ENT_LO;
                state_next = S_WR1;
            end
            S_WR1: begin
                cmd.mem_we   = 1'b1;
                cmd.asel     = usf_pkg::ASEL_POS1;
                cmd.wsel     = usf_pkg::WSEL_ENT_HI;
                cmd.pos_step = 1'b1;
                state_next   = S_W_TEST;
            end
            S_DONE: begin
                push                = 1'b1;
                push_res.fix_status = status_reg;
                state_next          = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= usf_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    a_read_pushes : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == usf_pkg::KIND_READ) |=> push)
        else $error("read transfer did not produce a result next cycle");

    a_load_pushes : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == usf_pkg::KIND_LOAD) |-> (push && cmd.mem_we))
        else $error("load transfer did not write and answer at once");

endmodule

// ----- design/usf_outq.sv -----
module usf_outq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  usf_pkg::res_t                    push_res,
    output logic                             full,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [usf_pkg::M_TDATA_W-1:0]    m_tdata
);

    usf_pkg::res_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          pop;

    assign m_tvalid = cnt_reg != 2'd0;
    assign full     = cnt_reg == 2'd2;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = usf_pkg::M_TDATA_W'(q_reg[rd_ptr_reg]);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("result pushed into a full queue");

    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

// ----- dv/tb_update_sequence_fixup.sv -----
`timescale 1ns / 100ps

module tb_update_sequence_fixup;

    localparam int REC_BYTES = 4096;
    localparam int HDR_BYTES = 48;
    localparam logic [31:0] DEF_MAGIC = usf_pkg::MAGIC_RST;
    // register slot past the end of the list, writes to it must do nothing
    localparam logic [usf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // unassigned kind code, the block answers zeros and changes nothing
    localparam logic [usf_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct {
        logic [usf_pkg::KIND_W-1:0]    kind;
        logic [usf_pkg::IN_ADDR_W-1:0] addr;
        logic [usf_pkg::BYTE_W-1:0]    value;
    } rec_item_t;

    typedef struct {
        logic [usf_pkg::BYTE_W-1:0] read_byte;
        usf_pkg::status_t           fix_status;
    } fix_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [usf_pkg::S_TDATA_W-1:0]  s_tdata = '0;   // [11:0] byte_address, [19:12] byte_value
    logic [usf_pkg::KIND_W-1:0]     s_tuser = '0;   // [1:0] kind
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [usf_pkg::M_TDATA_W-1:0]  m_tdata;        // [7:0] read_byte, [9:8] fix_status
    logic                           cfg_wr_en = 1'b0;
    logic [usf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [usf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow of the record store and of the registers, as the block should hold them
    logic [usf_pkg::BYTE_W-1:0]  record_copy [0:REC_BYTES-1];
    logic [usf_pkg::LEN_W-1:0]   cur_length = usf_pkg::LEN_RST;
    logic [usf_pkg::MAGIC_W-1:0] cur_magic = usf_pkg::MAGIC_RST;
    logic [usf_pkg::SHIFT_W-1:0] cur_shift = usf_pkg::SHIFT_RST;

    // results owed by the block, oldest first
    fix_result_t due_results[$];
    // items waiting to go out on the input channel
    rec_item_t   pending_items[$];
    rec_item_t   drv_item;

    // which store bytes the stimulus has loaded so far, reads only ever go there
    bit written [0:REC_BYTES-1];
    int written_addrs[$];

    int gen_count = 0;
    int accepted_cnt = 0;
    int result_cnt = 0;
    int err_count = 0;

    update_sequence_fixup #(
        .RECORD_BYTES (REC_BYTES),
        .HEADER_BYTES (HDR_BYTES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [15:0] word_at(input longint unsigned a);
        return {record_copy[a + 1], record_copy[a]};
    endfunction

    // header checks, then the sector walk; a failing sector stops the walk and
    // leaves the sectors before it patched
    function automatic usf_pkg::status_t fixup_status();
        longint unsigned len, sector, pos, entry, usa_off, count;
        logic [31:0] sig;
        logic [15:0] usn;
        len = cur_length;
        sector = 64'd1 << cur_shift;
        if (len > REC_BYTES) return usf_pkg::ST_CORRUPT;
        if (len < HDR_BYTES) return usf_pkg::ST_CORRUPT;
        sig = {record_copy[3], record_copy[2], record_copy[1], record_copy[0]};
        if (sig != cur_magic) return usf_pkg::ST_MAGIC;
        usa_off = word_at(4);
        count = word_at(6);
        if (usa_off + 2 > len) return usf_pkg::ST_CORRUPT;
        // a count of zero never matches
        if (count == 0 || count - 1 != (len >> cur_shift)) return usf_pkg::ST_CORRUPT;
        usn = word_at(usa_off);
        entry = usa_off;
        // a one-byte sector wraps here and always fails
        if (len < sector - 2) return usf_pkg::ST_CORRUPT;
        for (pos = sector - 2; pos + 2 <= len; pos += sector) begin
            entry += 2;
            if (entry + 2 > len) return usf_pkg::ST_CORRUPT;
            if (word_at(pos) != usn) return usf_pkg::ST_CORRUPT;
            record_copy[pos] = record_copy[entry];
            record_copy[pos + 1] = record_copy[entry + 1];
        end
        return usf_pkg::ST_OK;
    endfunction

    // every accepted item owes exactly one result
    task automatic apply_item(input rec_item_t it);
        fix_result_t r;
        r.read_byte = '0;
        r.fix_status = usf_pkg::ST_OK;
        case (it.kind)
            usf_pkg::KIND_LOAD: record_copy[it.addr] = it.value;
            usf_pkg::KIND_FIXUP: r.fix_status = fixup_status();
            usf_pkg::KIND_READ: r.read_byte = record_copy[it.addr];
            default: ;
        endcase
        due_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // stretch of the run where neither side idles
    function automatic bit steady_span(input int n);
        return n >= 800 && n < 1200;
    endfunction

    // ------------------------------------------------------------------
    // input driver: holds an item until its transfer, gaps at random
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(drv_item);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 &&
                    (steady_span(accepted_cnt) || $urandom_range(0, 99) >= 6)) begin
                    drv_item = pending_items.pop_front();
                    s_tdata <= usf_pkg::S_TDATA_W'({drv_item.value, drv_item.addr});
                    s_tuser <= drv_item.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: compares each result transfer with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        fix_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d (%04h) with nothing owed",
                                              result_cnt, m_tdata));
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[usf_pkg::BYTE_W-1:0] !== want.read_byte)
                        report_mismatch($sformatf("result %0d read_byte %02h, expected %02h",
                                                  result_cnt, m_tdata[usf_pkg::BYTE_W-1:0],
                                                  want.read_byte));
                    if (m_tdata[usf_pkg::BYTE_W+1:usf_pkg::BYTE_W] !== want.fix_status)
                        report_mismatch($sformatf("result %0d fix_status %0d, expected %0d",
                                                  result_cnt,
                                                  m_tdata[usf_pkg::BYTE_W+1:usf_pkg::BYTE_W],
                                                  want.fix_status));
                end
            end
            m_tready <= steady_span(result_cnt) || ($urandom_range(0, 99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic push_item(input logic [usf_pkg::KIND_W-1:0] kind, input int addr,
                             input int value);
        rec_item_t it;
        it.kind = kind;
        it.addr = addr[usf_pkg::IN_ADDR_W-1:0];
        it.value = value[usf_pkg::BYTE_W-1:0];
        if (kind == usf_pkg::KIND_LOAD && !written[it.addr]) begin
            written[it.addr] = 1'b1;
            written_addrs.push_back(addr);
        end
        pending_items.push_back(it);
        gen_count++;
    endtask

    // little-endian word, bytes past the store are dropped
    task automatic load_word(input int a, input logic [15:0] w);
        if (a < REC_BYTES) push_item(usf_pkg::KIND_LOAD, a, w[7:0]);
        if (a + 1 < REC_BYTES) push_item(usf_pkg::KIND_LOAD, a + 1, w[15:8]);
    endtask

    function automatic int any_written();
        return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    endfunction

    // stray loads, reads of loaded bytes and unassigned kinds between records
    task automatic push_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            push_item(usf_pkg::KIND_LOAD, $urandom_range(0, REC_BYTES - 1),
                      $urandom_range(0, 255));
        else if (r < 85)
            push_item(usf_pkg::KIND_READ, any_written(), $urandom_range(0, 255));
        else
            push_item(KIND_NONE, any_written(), $urandom_range(0, 255));
    endtask

    // one record built for the current registers, then a fixup; about half are
    // sound, the rest carry one flaw. the header goes in last, so the walk only
    // ever touches bytes loaded here
    task automatic push_record_run();
        int len, sh, nsect, count, usa_off, hi, flaw, bad_k, k, bit_i;
        logic [15:0] usn;
        logic [31:0] sig;
        len = cur_length;
        sh = cur_shift;
        // sectors the walk visits when the header passes
        nsect = 0;
        if (len <= REC_BYTES && sh >= 1 && sh < 13 && len >= (1 << sh) - 2) nsect = len >> sh;
        count = (len >> sh) + 1;
        hi = (len < REC_BYTES ? len : REC_BYTES) - 2 * count;
        if (hi < 8) hi = 8;
        usa_off = $urandom_range(8, hi);
        sig = cur_magic;
        usn = 16'($urandom);
        flaw = $urandom_range(0, 9);
        bad_k = (nsect > 0) ? $urandom_range(1, nsect) : 0;
        case (flaw)
            5: begin
                // wrong signature
                bit_i = $urandom_range(0, 31);
                sig[bit_i] = ~sig[bit_i];
            end
            6: begin
                // array start leaves no room for the sequence number
                usa_off = (len >= 1 ? len - 1 : 0) + $urandom_range(0, 3);
            end
            7: begin
                // entry count off, zero among them
                count = $urandom_range(0, 1) ? 0 : count + $urandom_range(1, 3);
            end
            8: begin
                // array runs past the record end
                if (nsect > 0) begin
                    usa_off = len - 2 * nsect - 1 + $urandom_range(0, 2 * nsect - 1);
                    if (usa_off < 0) usa_off = 0;
                end
            end
            default: ;
        endcase
        if (usa_off + 1 < REC_BYTES) load_word(usa_off, usn);
        for (k = 1; k <= nsect; k++) begin
            if (usa_off + 2 * k + 1 < REC_BYTES) load_word(usa_off + 2 * k, 16'($urandom));
        end
        // sector-end words, one of them spoiled for a mismatch flaw
        for (k = 1; k <= nsect; k++) begin
            load_word(k * (1 << sh) - 2,
                      (flaw == 9 && k == bad_k) ? usn ^ 16'($urandom_range(1, 65535)) : usn);
        end
        load_word(0, sig[15:0]);
        load_word(2, sig[31:16]);
        load_word(4, 16'(usa_off));
        load_word(6, 16'(count));
        push_item(usf_pkg::KIND_FIXUP, any_written(), $urandom_range(0, 255));
    endtask

    // block idle: nothing queued, nothing in flight, nothing owed
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [usf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [usf_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            usf_pkg::CFG_LENGTH: cur_length = val[usf_pkg::LEN_W-1:0];
            usf_pkg::CFG_MAGIC: cur_magic = val;
            usf_pkg::CFG_SHIFT: cur_shift = val[usf_pkg::SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    // new register setting, then a batch of records with noise between them
    task automatic run_phase(input int len, input logic [31:0] magic, input int shift,
                             input int runs);
        wait_drained();
        write_reg(usf_pkg::CFG_LENGTH, len);
        write_reg(usf_pkg::CFG_MAGIC, magic);
        write_reg(usf_pkg::CFG_SHIFT, shift);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (runs) begin
            push_record_run();
            repeat ($urandom_range(0, 4)) push_noise();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a sound record at the reset settings (1024 bytes, 512-byte
        // sectors), array at 48 with sequence number and two entries
        load_word(0, DEF_MAGIC[15:0]);
        load_word(2, DEF_MAGIC[31:16]);
        load_word(4, 16'd48);
        load_word(6, 16'd3);
        load_word(48, 16'hA55A);
        load_word(50, 16'hFF00);
        load_word(52, 16'h00FF);
        load_word(510, 16'hA55A);
        load_word(1022, 16'hA55A);
        push_item(usf_pkg::KIND_LOAD, REC_BYTES - 1, 8'hFF);
        push_item(usf_pkg::KIND_READ, REC_BYTES - 1, 8'h00);
        push_item(usf_pkg::KIND_FIXUP, 0, 8'hFF);
        // patched sector ends now hold the entries
        push_item(usf_pkg::KIND_READ, 510, 8'h00);
        push_item(usf_pkg::KIND_READ, 1023, 8'h00);
        push_item(KIND_NONE, REC_BYTES - 1, 8'hFF);
        // second pass finds entries where the sequence number was
        push_item(usf_pkg::KIND_FIXUP, REC_BYTES - 1, 8'h00);

        // settings sweep, extremes included
        run_phase(1024, DEF_MAGIC, 9, 10);
        run_phase(512, DEF_MAGIC, 8, 10);
        run_phase(4096, DEF_MAGIC, 12, 4);
        run_phase(4094, 32'hFFFF_FFFF, 12, 3);          // sound with no sector visited
        run_phase(4096, $urandom, 9, 3);
        run_phase(48, 32'h0000_0000, 8, 5);             // sector larger than the record
        run_phase(47, DEF_MAGIC, 9, 3);                 // short record
        run_phase(0, 32'hFFFF_FFFF, 8, 3);
        run_phase(4097, DEF_MAGIC, 9, 3);               // length past the store
        run_phase(8191, DEF_MAGIC, 15, 3);
        run_phase(48, DEF_MAGIC, 0, 3);                 // one-byte sectors
        run_phase(64, $urandom, 2, 3);
        run_phase(300, $urandom, 8, 6);                 // length not a sector multiple
        run_phase(2048, DEF_MAGIC, 10, 6);
        run_phase(200, DEF_MAGIC, 4, 3);

        // random settings until the item budget is spent
        while (gen_count < 1950)
            run_phase($urandom_range(HDR_BYTES, 1100),
                      $urandom_range(0, 1) ? DEF_MAGIC : 32'($urandom),
                      $urandom_range(8, 10), 6);

        wait_drained();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
